// ===== rtl/gas_pkg.sv =====
// gas_pkg: shared codes, field widths and controller/datapath link types
// for the grid A* step block; no dependencies
package gas_pkg;

  localparam int OP_W   = 2;
  localparam int CRD_W  = 5;
  localparam int CST_W  = 9;
  localparam int PIX_W  = 10;
  localparam int ST_W   = 2;
  localparam int LEN_W  = 11;
  localparam int CIDX_W = 2;

  typedef enum logic [OP_W-1:0] {
    OP_LOAD    = 2'd0,
    OP_RESTART = 2'd1,
    OP_STEP    = 2'd2,
    OP_READ    = 2'd3
  } op_t;

  localparam logic [ST_W-1:0] ST_OK     = 2'd0;
  localparam logic [ST_W-1:0] ST_GOAL   = 2'd1;
  localparam logic [ST_W-1:0] ST_EMPTY  = 2'd2;
  localparam logic [ST_W-1:0] ST_BEYOND = 2'd3;

  localparam logic [CIDX_W-1:0] CFG_START_X = 2'd0;
  localparam logic [CIDX_W-1:0] CFG_START_Y = 2'd1;
  localparam logic [CIDX_W-1:0] CFG_GOAL_X  = 2'd2;
  localparam logic [CIDX_W-1:0] CFG_GOAL_Y  = 2'd3;

  localparam logic [1:0] MK_UNSEEN = 2'd0;
  localparam logic [1:0] MK_OPEN   = 2'd1;
  localparam logic [1:0] MK_CLOSED = 2'd2;

  localparam logic [1:0] DIR_LEFT  = 2'd0;
  localparam logic [1:0] DIR_DOWN  = 2'd1;
  localparam logic [1:0] DIR_RIGHT = 2'd2;
  localparam logic [1:0] DIR_UP    = 2'd3;

  typedef enum logic [2:0] {
    EM_PLAIN  = 3'd0,
    EM_GOAL   = 3'd1,
    EM_EMPTY  = 3'd2,
    EM_STEP   = 3'd3,
    EM_PATH   = 3'd4,
    EM_BEYOND = 3'd5
  } emit_t;

  typedef struct packed {
    logic  capture;
    logic  load_cost;
    logic  clear_start;
    logic  clear_run;
    logic  restart_init;
    logic  scan_start;
    logic  scan_run;
    logic  remove_rd;
    logic  remove_wr;
    logic  relax_rd;
    logic  relax_wr;
    logic  path_wr;
    logic  path_rd;
    logic  emit;
    emit_t kind;
  } gas_cmd_t;

  typedef struct packed {
    op_t  op;
    logic goal_found;
    logic open_empty;
    logic path_idx_ok;
    logic clear_last;
    logic scan_done;
    logic is_goal;
    logic last_dir;
    logic path_stop;
    logic parent_bad;
    logic out_free;
  } gas_stat_t;

endpackage

// ===== rtl/gas_if.sv =====
// gas_in_if / gas_out_if: valid-ready channels for items and results
// depends on gas_pkg for field widths
interface gas_in_if import gas_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [OP_W-1:0]         operation;
  logic [CRD_W-1:0]        cell_x;
  logic [CRD_W-1:0]        cell_y;
  logic signed [CST_W-1:0] cell_cost;
  logic [PIX_W-1:0]        path_index;

  modport source (output valid, operation, cell_x, cell_y, cell_cost, path_index,
                  input ready);
  modport sink   (input valid, operation, cell_x, cell_y, cell_cost, path_index,
                  output ready);
endinterface

interface gas_out_if import gas_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [ST_W-1:0]  status;
  logic [CRD_W-1:0] node_x;
  logic [CRD_W-1:0] node_y;
  logic [LEN_W-1:0] path_length;

  modport source (output valid, status, node_x, node_y, path_length, input ready);
  modport sink   (input valid, status, node_x, node_y, path_length, output ready);
endinterface

// ===== rtl/gas_ram.sv =====
// gas_ram: generic single-write, single-read memory with registered read
// no dependencies
module gas_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== rtl/gas_ctrl.sv =====
// gas_ctrl: sequencer for load, restart, step and path read
// depends on gas_pkg for command and status types
module gas_ctrl import gas_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  gas_stat_t st,
  output gas_cmd_t  cmd
);
  typedef enum logic [11:0] {
    S_IDLE     = 12'b0000_0000_0001,
    S_DECODE   = 12'b0000_0000_0010,
    S_CLEAR    = 12'b0000_0000_0100,
    S_INIT     = 12'b0000_0000_1000,
    S_SCAN     = 12'b0000_0001_0000,
    S_REMOVE   = 12'b0000_0010_0000,
    S_SETTLE   = 12'b0000_0100_0000,
    S_RELAX_RD = 12'b0000_1000_0000,
    S_RELAX_WR = 12'b0001_0000_0000,
    S_PATH_WR  = 12'b0010_0000_0000,
    S_PATH_RD  = 12'b0100_0000_0000,
    S_EMIT     = 12'b1000_0000_0000
  } state_t;

  state_t state_r, state_nxt;
  emit_t  kind_r, kind_nxt;

  always_comb begin
    state_nxt = state_r;
    kind_nxt  = kind_r;
    cmd       = '0;
    cmd.kind  = kind_r;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_DECODE;
        end
      end
      S_DECODE: begin
        unique case (st.op)
          OP_LOAD: begin
            cmd.load_cost = 1'b1;
            kind_nxt      = EM_PLAIN;
            state_nxt     = S_EMIT;
          end
          OP_RESTART: begin
            cmd.clear_start = 1'b1;
            state_nxt       = S_CLEAR;
          end
          OP_STEP: begin
            if (st.goal_found) begin
              kind_nxt  = EM_GOAL;
              state_nxt = S_EMIT;
            end else if (st.open_empty) begin
              kind_nxt  = EM_EMPTY;
              state_nxt = S_EMIT;
            end else begin
              cmd.scan_start = 1'b1;
              state_nxt      = S_SCAN;
            end
          end
          OP_READ: begin
            kind_nxt  = st.path_idx_ok ? EM_PATH : EM_BEYOND;
            state_nxt = S_EMIT;
          end
          default: state_nxt = S_EMIT;
        endcase
      end
      S_CLEAR: begin
        cmd.clear_run = 1'b1;
        if (st.clear_last) state_nxt = S_INIT;
      end
      S_INIT: begin
        cmd.restart_init = 1'b1;
        kind_nxt         = EM_PLAIN;
        state_nxt        = S_EMIT;
      end
      S_SCAN: begin
        cmd.scan_run = 1'b1;
        if (st.scan_done) state_nxt = S_REMOVE;
      end
      S_REMOVE: begin
        cmd.remove_rd = 1'b1;
        state_nxt     = S_SETTLE;
      end
      S_SETTLE: begin
        cmd.remove_wr = 1'b1;
        state_nxt     = st.is_goal ? S_PATH_WR : S_RELAX_RD;
      end
      S_RELAX_RD: begin
        cmd.relax_rd = 1'b1;
        state_nxt    = S_RELAX_WR;
      end
      S_RELAX_WR: begin
        cmd.relax_wr = 1'b1;
        if (st.last_dir) begin
          kind_nxt  = EM_STEP;
          state_nxt = S_EMIT;
        end else begin
          state_nxt = S_RELAX_RD;
        end
      end
      S_PATH_WR: begin
        cmd.path_wr = 1'b1;
        if (st.path_stop) begin
          kind_nxt  = EM_GOAL;
          state_nxt = S_EMIT;
        end else begin
          state_nxt = S_PATH_RD;
        end
      end
      S_PATH_RD: begin
        cmd.path_rd = 1'b1;
        if (st.parent_bad) begin
          kind_nxt  = EM_GOAL;
          state_nxt = S_EMIT;
        end else begin
          state_nxt = S_PATH_WR;
        end
      end
      S_EMIT: begin
        if (st.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      kind_r  <= EM_PLAIN;
    end else begin
      state_r <= state_nxt;
      kind_r  <= kind_nxt;
    end
  end
endmodule

// ===== rtl/gas_dp.sv =====
// gas_dp: node, cost, open list and path memories with scan, relax and
// path-walk logic; depends on gas_pkg and gas_ram
module gas_dp import gas_pkg::*; #(
  parameter int GRID_WIDTH  = 32,
  parameter int GRID_HEIGHT = 32
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  gas_cmd_t                cmd,
  output gas_stat_t               st,
  input  logic [OP_W-1:0]         in_operation,
  input  logic [CRD_W-1:0]        in_cell_x,
  input  logic [CRD_W-1:0]        in_cell_y,
  input  logic signed [CST_W-1:0] in_cell_cost,
  input  logic [PIX_W-1:0]        in_path_index,
  input  logic                    cfg_we,
  input  logic [CIDX_W-1:0]       cfg_index,
  input  logic [CRD_W-1:0]        cfg_wdata,
  input  logic                    out_ready,
  output logic                    out_valid,
  output logic [ST_W-1:0]         out_status,
  output logic [CRD_W-1:0]        out_node_x,
  output logic [CRD_W-1:0]        out_node_y,
  output logic [LEN_W-1:0]        out_path_length
);
  localparam int CELLS = GRID_WIDTH * GRID_HEIGHT;
  localparam int XW    = $clog2(GRID_WIDTH);
  localparam int YW    = $clog2(GRID_HEIGHT);
  localparam int CW    = $clog2(CELLS);
  localparam int NW    = $clog2(CELLS + 1);
  localparam int PW    = XW + YW;
  localparam int GW    = CW + 8;
  localparam int XE    = (XW > CRD_W) ? XW : CRD_W;
  localparam int YE    = (YW > CRD_W) ? YW : CRD_W;
  localparam int HW    = ((XE > YE) ? XE : YE) + 1;
  localparam int FW    = GW + 1;
  localparam int NDW   = 4 + CW + GW;

  // configuration
  logic [CRD_W-1:0] start_x_r, start_y_r, goal_x_r, goal_y_r;

  // captured item
  op_t                     op_r;
  logic [CRD_W-1:0]        cx_r, cy_r;
  logic signed [CST_W-1:0] cost_r;
  logic [PIX_W-1:0]        pidx_r;

  // search state
  logic [NW-1:0] open_cnt_r, order_cnt_r, path_cnt_r, pn_r, iss_r;
  logic          goal_found_r;
  logic [PW-1:0] root_r, path_goal_r, walk_r;
  logic [CW-1:0] clr_k_r;
  logic [1:0]    dir_r;

  // scan pipeline and running best
  logic          s1_v_r, s2_v_r, best_v_r;
  logic [CW-1:0] s1_idx_r, s2_idx_r, best_idx_r;
  logic [PW-1:0] s2_pair_r, best_pair_r;
  logic [FW-1:0] best_f_r;
  logic [CW-1:0] best_ord_r;
  logic [GW-1:0] best_g_r;
  logic [1:0]    best_dir_r;

  // relax neighbour
  logic          nb_v_r;
  logic [PW-1:0] nb_pair_r;

  // output register
  logic             out_v_r;
  logic [ST_W-1:0]  out_st_r;
  logic [CRD_W-1:0] out_x_r, out_y_r;
  logic [LEN_W-1:0] out_len_r;

  // memory ports
  logic           node_we, cost_we, oe_we, path_we;
  logic [CW-1:0]  node_wa, node_ra, cost_wa, cost_ra, oe_wa, oe_ra, path_wa, path_ra;
  logic [NDW-1:0] node_wd, node_rd;
  logic [CST_W-1:0] cost_rd;
  logic [PW-1:0]  oe_wd, oe_rd, path_wd, path_rd;

  function automatic logic [CW-1:0] cell_addr(input logic [PW-1:0] p);
    cell_addr = CW'(32'(p[PW-1:XW]) * GRID_WIDTH + 32'(p[XW-1:0]));
  endfunction

  function automatic logic [HW-1:0] heur(input logic [PW-1:0] p);
    logic [XE-1:0] xa, ga, dx;
    logic [YE-1:0] ya, gb, dy;
    xa   = XE'(p[XW-1:0]);
    ga   = XE'(goal_x_r);
    ya   = YE'(p[PW-1:XW]);
    gb   = YE'(goal_y_r);
    dx   = (xa > ga) ? xa - ga : ga - xa;
    dy   = (ya > gb) ? ya - gb : gb - ya;
    heur = HW'(dx) + HW'(dy);
  endfunction

  // neighbour in direction d, with an in-grid flag on top
  function automatic logic [PW:0] nbr(input logic [PW-1:0] p, input logic [1:0] d);
    logic [XW:0] nx;
    logic [YW:0] ny;
    logic        ok;
    nx = {1'b0, p[XW-1:0]};
    ny = {1'b0, p[PW-1:XW]};
    case (d)
      DIR_LEFT:  nx = nx - 1'b1;
      DIR_DOWN:  ny = ny + 1'b1;
      DIR_RIGHT: nx = nx + 1'b1;
      default:   ny = ny - 1'b1;
    endcase
    ok  = (32'(nx) < GRID_WIDTH) && (32'(ny) < GRID_HEIGHT);
    nbr = {ok, ny[YW-1:0], nx[XW-1:0]};
  endfunction

  function automatic logic [PW-1:0] to_pair(input logic [CRD_W-1:0] x,
                                            input logic [CRD_W-1:0] y);
    logic [XE-1:0] xe;
    logic [YE-1:0] ye;
    xe      = XE'(x);
    ye      = YE'(y);
    to_pair = {ye[YW-1:0], xe[XW-1:0]};
  endfunction

  // derived values
  logic          load_ok, start_ok;
  logic [PW-1:0] load_pair, start_pair;
  logic [PW:0]   rnb, pnb;
  logic [FW-1:0] cand_f;
  logic [CW-1:0] cand_ord;
  logic          cand_better;
  logic [GW-1:0] g_new;
  logic [1:0]    nb_mark;
  logic          rx_skip, rx_new, rx_better;
  logic [NW-1:0] cnt_dec, pn_inc;
  logic [XE-1:0] bx_e, gx_e;
  logic [YE-1:0] by_e, gy_e;
  logic          walk_stop;

  assign load_ok    = (32'(cx_r) < GRID_WIDTH) && (32'(cy_r) < GRID_HEIGHT);
  assign start_ok   = (32'(start_x_r) < GRID_WIDTH) && (32'(start_y_r) < GRID_HEIGHT);
  assign load_pair  = to_pair(cx_r, cy_r);
  assign start_pair = to_pair(start_x_r, start_y_r);
  assign rnb        = nbr(best_pair_r, dir_r);
  // parent lies opposite to the recorded step
  assign pnb        = nbr(walk_r, node_rd[GW+CW+1:GW+CW] ^ 2'b10);

  assign cand_f   = FW'(node_rd[GW-1:0]) + FW'(heur(s2_pair_r));
  assign cand_ord = node_rd[GW+CW-1:GW];
  assign cand_better = !best_v_r || (cand_f < best_f_r) ||
                       ((cand_f == best_f_r) && (cand_ord < best_ord_r));

  assign g_new     = best_g_r + GW'(cost_rd[CST_W-2:0]);
  assign nb_mark   = node_rd[NDW-1:NDW-2];
  assign rx_skip   = !nb_v_r || cost_rd[CST_W-1] || (nb_mark == MK_CLOSED);
  assign rx_new    = !rx_skip && (nb_mark == MK_UNSEEN);
  assign rx_better = !rx_skip && (nb_mark != MK_UNSEEN) && (g_new < node_rd[GW-1:0]);

  assign cnt_dec   = open_cnt_r - NW'(1);
  assign pn_inc    = pn_r + NW'(1);
  assign walk_stop = (walk_r == root_r) || (32'(pn_inc) >= CELLS);

  assign bx_e = XE'(best_pair_r[XW-1:0]);
  assign by_e = YE'(best_pair_r[PW-1:XW]);
  assign gx_e = XE'(goal_x_r);
  assign gy_e = YE'(goal_y_r);

  always_comb begin
    st             = '0;
    st.op          = op_r;
    st.goal_found  = goal_found_r;
    st.open_empty  = (open_cnt_r == '0);
    st.path_idx_ok = (32'(pidx_r) < 32'(path_cnt_r));
    st.clear_last  = (32'(clr_k_r) == CELLS - 1);
    st.scan_done   = (iss_r == open_cnt_r) && !s1_v_r && !s2_v_r;
    st.is_goal     = (bx_e == gx_e) && (by_e == gy_e);
    st.last_dir    = (dir_r == DIR_UP);
    st.path_stop   = walk_stop;
    st.parent_bad  = !pnb[PW];
    st.out_free    = !out_v_r || out_ready;
  end

  // memory port steering
  always_comb begin
    node_we = 1'b0;
    node_wa = '0;
    node_wd = '0;
    node_ra = '0;
    cost_we = cmd.load_cost && load_ok;
    cost_wa = cell_addr(load_pair);
    cost_ra = '0;
    oe_we   = 1'b0;
    oe_wa   = '0;
    oe_wd   = '0;
    oe_ra   = iss_r[CW-1:0];
    path_we = cmd.path_wr;
    path_wa = pn_r[CW-1:0];
    path_wd = walk_r;
    // path is stored goal first, so index from the far end
    path_ra = CW'(32'(path_cnt_r) - 32'(pidx_r) - 32'd1);

    if (cmd.scan_run) node_ra = cell_addr(oe_rd);
    if (cmd.relax_rd && rnb[PW]) begin
      node_ra = cell_addr(rnb[PW-1:0]);
      cost_ra = cell_addr(rnb[PW-1:0]);
    end
    if (cmd.path_wr) node_ra = cell_addr(walk_r);

    if (cmd.clear_run) begin
      node_we = 1'b1;
      node_wa = clr_k_r;
    end
    if (cmd.restart_init && start_ok) begin
      node_we = 1'b1;
      node_wa = cell_addr(start_pair);
      node_wd = {MK_OPEN, {(NDW-2){1'b0}}};
      oe_we   = 1'b1;
      oe_wa   = '0;
      oe_wd   = start_pair;
    end
    if (cmd.remove_rd) begin
      node_we = 1'b1;
      node_wa = cell_addr(best_pair_r);
      node_wd = {MK_CLOSED, best_dir_r, best_ord_r, best_g_r};
      oe_ra   = cnt_dec[CW-1:0];
    end
    if (cmd.remove_wr) begin
      oe_we = 1'b1;
      oe_wa = best_idx_r;
      oe_wd = oe_rd;
    end
    if (cmd.relax_wr && (rx_new || rx_better)) begin
      node_we = 1'b1;
      node_wa = cell_addr(nb_pair_r);
      node_wd = {MK_OPEN, dir_r, rx_new ? order_cnt_r[CW-1:0] : cand_ord, g_new};
    end
    if (cmd.relax_wr && rx_new && (32'(open_cnt_r) < CELLS)) begin
      oe_we = 1'b1;
      oe_wa = open_cnt_r[CW-1:0];
      oe_wd = nb_pair_r;
    end
  end

  gas_ram #(.WIDTH(NDW), .DEPTH(CELLS)) u_node (
    .clk(clk), .we(node_we), .waddr(node_wa), .wdata(node_wd),
    .raddr(node_ra), .rdata(node_rd)
  );
  gas_ram #(.WIDTH(CST_W), .DEPTH(CELLS)) u_cost (
    .clk(clk), .we(cost_we), .waddr(cost_wa), .wdata(cost_r),
    .raddr(cost_ra), .rdata(cost_rd)
  );
  gas_ram #(.WIDTH(PW), .DEPTH(CELLS)) u_open (
    .clk(clk), .we(oe_we), .waddr(oe_wa), .wdata(oe_wd),
    .raddr(oe_ra), .rdata(oe_rd)
  );
  gas_ram #(.WIDTH(PW), .DEPTH(CELLS)) u_path (
    .clk(clk), .we(path_we), .waddr(path_wa), .wdata(path_wd),
    .raddr(path_ra), .rdata(path_rd)
  );

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_x_r    <= '0;
      start_y_r    <= '0;
      goal_x_r     <= '0;
      goal_y_r     <= '0;
      open_cnt_r   <= '0;
      order_cnt_r  <= '0;
      path_cnt_r   <= '0;
      goal_found_r <= 1'b0;
      root_r       <= '0;
      s1_v_r       <= 1'b0;
      s2_v_r       <= 1'b0;
      best_v_r     <= 1'b0;
      out_v_r      <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_START_X: start_x_r <= cfg_wdata;
          CFG_START_Y: start_y_r <= cfg_wdata;
          CFG_GOAL_X:  goal_x_r  <= cfg_wdata;
          CFG_GOAL_Y:  goal_y_r  <= cfg_wdata;
          default: ;
        endcase
      end

      if (cmd.clear_start) begin
        open_cnt_r   <= '0;
        order_cnt_r  <= '0;
        path_cnt_r   <= '0;
        goal_found_r <= 1'b0;
      end
      if (cmd.restart_init && start_ok) begin
        open_cnt_r  <= NW'(1);
        order_cnt_r <= NW'(1);
        root_r      <= start_pair;
      end

      if (cmd.scan_start) begin
        s1_v_r   <= 1'b0;
        s2_v_r   <= 1'b0;
        best_v_r <= 1'b0;
      end else if (cmd.scan_run) begin
        s1_v_r <= (iss_r != open_cnt_r);
        s2_v_r <= s1_v_r;
        if (s2_v_r && cand_better) best_v_r <= 1'b1;
      end

      if (cmd.remove_wr) open_cnt_r <= cnt_dec;
      if (cmd.relax_wr && rx_new) begin
        order_cnt_r <= order_cnt_r + NW'(1);
        if (32'(open_cnt_r) < CELLS) open_cnt_r <= open_cnt_r + NW'(1);
      end

      if (cmd.path_wr && walk_stop) begin
        path_cnt_r   <= pn_inc;
        goal_found_r <= 1'b1;
      end
      if (cmd.path_rd && !pnb[PW]) begin
        path_cnt_r   <= pn_r;
        goal_found_r <= 1'b1;
      end

      if (cmd.emit) begin
        out_v_r <= 1'b1;
      end else if (out_ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r   <= op_t'(in_operation);
      cx_r   <= in_cell_x;
      cy_r   <= in_cell_y;
      cost_r <= in_cell_cost;
      pidx_r <= in_path_index;
    end
    if (cmd.clear_start) clr_k_r <= '0;
    else if (cmd.clear_run) clr_k_r <= clr_k_r + CW'(1);

    if (cmd.scan_start) begin
      iss_r <= '0;
    end else if (cmd.scan_run) begin
      if (iss_r != open_cnt_r) begin
        iss_r    <= iss_r + NW'(1);
        s1_idx_r <= iss_r[CW-1:0];
      end
      s2_idx_r  <= s1_idx_r;
      s2_pair_r <= oe_rd;
      if (s2_v_r && cand_better) begin
        best_idx_r  <= s2_idx_r;
        best_pair_r <= s2_pair_r;
        best_f_r    <= cand_f;
        best_ord_r  <= cand_ord;
        best_g_r    <= node_rd[GW-1:0];
        best_dir_r  <= node_rd[GW+CW+1:GW+CW];
      end
    end

    if (cmd.remove_wr) begin
      dir_r  <= DIR_LEFT;
      walk_r <= best_pair_r;
      pn_r   <= '0;
    end
    if (cmd.relax_rd) begin
      nb_v_r    <= rnb[PW];
      nb_pair_r <= rnb[PW-1:0];
    end
    if (cmd.relax_wr) dir_r <= dir_r + 2'd1;

    if (cmd.path_wr) begin
      pn_r <= pn_inc;
      if (walk_stop) path_goal_r <= best_pair_r;
    end
    if (cmd.path_rd) begin
      if (pnb[PW]) walk_r <= pnb[PW-1:0];
      else         path_goal_r <= best_pair_r;
    end

    if (cmd.emit) begin
      logic [XE-1:0]    ox;
      logic [YE-1:0]    oy;
      logic [ST_W-1:0]  os;
      logic [LEN_W-1:0] ol;
      ox = '0;
      oy = '0;
      os = ST_OK;
      ol = LEN_W'(path_cnt_r);
      case (cmd.kind)
        EM_GOAL: begin
          os = ST_GOAL;
          ox = XE'(path_goal_r[XW-1:0]);
          oy = YE'(path_goal_r[PW-1:XW]);
        end
        EM_EMPTY: begin
          os = ST_EMPTY;
          ol = '0;
        end
        EM_STEP: begin
          ox = XE'(best_pair_r[XW-1:0]);
          oy = YE'(best_pair_r[PW-1:XW]);
          ol = '0;
        end
        EM_PATH: begin
          ox = XE'(path_rd[XW-1:0]);
          oy = YE'(path_rd[PW-1:XW]);
        end
        EM_BEYOND: os = ST_BEYOND;
        default: ;
      endcase
      out_st_r  <= os;
      out_len_r <= ol;
      out_x_r   <= ox[CRD_W-1:0];
      out_y_r   <= oy[CRD_W-1:0];
    end
  end

  assign out_valid       = out_v_r;
  assign out_status      = out_st_r;
  assign out_node_x      = out_x_r;
  assign out_node_y      = out_y_r;
  assign out_path_length = out_len_r;
endmodule

// ===== rtl/grid_astar_step_top.sv =====
// grid_astar_step_top: A* search step engine on a four-connected cost grid
// depends on gas_pkg, gas_if, gas_ctrl, gas_dp (and gas_ram below it)
//
//   channel  dir  beat contents
//   in_ch    in   operation, cell_x, cell_y, cell_cost, path_index
//   out_ch   out  status, node_x, node_y, path_length
//   cfg_*    in   write enable, register index, 5-bit data
//
// an item holds the block until its result is emitted; a restart runs a pass
// that clears every node mark, one per cycle, and a step runs the open list
// scan, which reads one entry per cycle
// a step that closes the goal walks the path instead of relaxing, and the
// walk also ends early when a parent lies outside the grid
// no clearing pass at reset: marks are only read after a restart
// items are taken only between operations; one finished result waits in the
// output register while the next item is accepted
module grid_astar_step_top import gas_pkg::*; #(
  parameter int GRID_WIDTH  = 32,
  parameter int GRID_HEIGHT = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  gas_in_if.sink            in_ch,
  gas_out_if.source         out_ch,
  input  logic              cfg_we,
  input  logic [CIDX_W-1:0] cfg_index,
  input  logic [CRD_W-1:0]  cfg_wdata
);
  gas_cmd_t  cmd;
  gas_stat_t st;
  logic      in_ready;

  gas_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_ch.valid), .in_ready(in_ready),
    .st(st), .cmd(cmd)
  );

  gas_dp #(.GRID_WIDTH(GRID_WIDTH), .GRID_HEIGHT(GRID_HEIGHT)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .st(st),
    .in_operation(in_ch.operation), .in_cell_x(in_ch.cell_x),
    .in_cell_y(in_ch.cell_y), .in_cell_cost(in_ch.cell_cost),
    .in_path_index(in_ch.path_index),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .out_ready(out_ch.ready), .out_valid(out_ch.valid),
    .out_status(out_ch.status), .out_node_x(out_ch.node_x),
    .out_node_y(out_ch.node_y), .out_path_length(out_ch.path_length)
  );

  assign in_ch.ready = in_ready;
endmodule

// ===== rtl/gas_chk.sv =====
// gas_chk: port-level checks for grid_astar_step_top, bound to the top level
// depends on gas_pkg for status codes and widths
module gas_chk import gas_pkg::*; (
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input logic [ST_W-1:0]  out_status,
  input logic [CRD_W-1:0] out_node_x,
  input logic [CRD_W-1:0] out_node_y,
  input logic [LEN_W-1:0] out_path_length
);
  logic [1:0] pend_r;
  logic       in_acc, out_acc;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  // items accepted but not yet delivered
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_r + {1'b0, in_acc} - {1'b0, out_acc};
    end
  end

  a_no_result_after_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result shown straight after reset");

  a_no_orphan_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (pend_r != 2'd0))
    else $error("result with no item behind it");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) &&
    $stable(out_path_length))
    else $error("stalled result changed");

  a_empty_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_EMPTY) |->
    (out_path_length == '0) && (out_node_x == '0) && (out_node_y == '0))
    else $error("empty open list result carries data");

  a_beyond_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_BEYOND) |-> (out_node_x == '0) && (out_node_y == '0))
    else $error("index beyond path shows a cell");
endmodule

bind grid_astar_step_top gas_chk u_chk (
  .clk(clk), .rst_n(rst_n),
  .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .out_status(out_ch.status), .out_node_x(out_ch.node_x),
  .out_node_y(out_ch.node_y), .out_path_length(out_ch.path_length)
);
